[rtl/pts_pkg.sv]
// shared constants, types and codes for the photometric table sampler
package pts_pkg;

    localparam int MAX_VERT        = 256;
    localparam int MAX_HORIZ       = 64;
    localparam int ANGLE_FRAC_BITS = 6;

    localparam int VERT_AW    = $clog2(MAX_VERT);
    localparam int HORIZ_AW   = $clog2(MAX_HORIZ);
    localparam int GRID_DEPTH = MAX_VERT * MAX_HORIZ;
    localparam int GRID_AW    = $clog2(GRID_DEPTH);
    localparam int SI_W       = (VERT_AW > HORIZ_AW) ? VERT_AW : HORIZ_AW;

    localparam int ONE_DEG    = 1 << ANGLE_FRAC_BITS;
    localparam int DEG90      = 90 * ONE_DEG;
    localparam int DEG90_LIM  = 90 * ONE_DEG + ONE_DEG / 2;
    localparam int DEG180     = 180 * ONE_DEG;
    localparam int DEG180_LIM = 180 * ONE_DEG + ONE_DEG / 2;
    localparam int DEG360     = 360 * ONE_DEG;
    localparam int WRAP_SLACK = ONE_DEG / 100;

    // working width of the folded horizontal angle
    localparam int PHI_W = 24;

    localparam int DIV_W = 26;

    localparam logic [1:0] KIND_VERT    = 2'd0;
    localparam logic [1:0] KIND_HORIZ   = 2'd1;
    localparam logic [1:0] KIND_CANDELA = 2'd2;
    localparam logic [1:0] KIND_SAMPLE  = 2'd3;

    localparam logic [1:0] REG_VERT_COUNT    = 2'd0;
    localparam logic [1:0] REG_HORIZ_COUNT   = 2'd1;
    localparam logic [1:0] REG_CANDELA_SCALE = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CD_WR,
        S_RD0,
        S_RD1,
        S_RD2,
        S_FOLD,
        S_ADJ_LO,
        S_ADJ_HI,
        S_MIRROR,
        S_LOC,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_TDIV,
        S_TWAIT,
        S_GRID,
        S_IC0,
        S_IC1,
        S_IPL,
        S_IPH,
        S_SUM,
        S_NORM,
        S_NWAIT,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        FOLD_NONE,
        FOLD_QUAD,
        FOLD_HALF,
        FOLD_WRAP
    } fold_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [15:0]      lo_bits;
        logic [DIV_W-1:0] den;
        logic [4:0]       steps;
    } div_req_t;

endpackage

[rtl/photometric_table_sampler.sv]
// top level: photometric table store and bilinear sampler
// Angle writes go straight to memory; candela writes are scaled, then
// written in S_CD_WR. A sample whose theta lies outside the vertical
// range ends once the table end points are read. Any other sample runs
// through reads of the first and last entries of both angle tables, a
// fold of phi by repeated 360-degree steps, two bisections over
// single-port memories with a read and a compare state per step, two
// weight divisions, four grid reads, five arithmetic steps and a
// normalizing division, which a saturated result skips. The bit-per-cycle
// divider and one port per memory set a sample's length. One item is
// in work at a time; a result waits in the output register, a finished
// sample in S_DONE while it is held. Tables are not cleared at reset.
module photometric_table_sampler (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [13:0]        index,
    input  logic signed [15:0] angle,
    input  logic signed [23:0] raw_candela,
    input  logic signed [15:0] theta,
    input  logic signed [15:0] phi,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        intensity,
    output logic               outside_range,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int VAW = pts_pkg::VERT_AW;
    localparam int HAW = pts_pkg::HORIZ_AW;
    localparam int GAW = pts_pkg::GRID_AW;
    localparam int SW  = pts_pkg::SI_W;
    localparam int PW  = pts_pkg::PHI_W;

    pts_pkg::state_t state_reg, state_next;
    pts_pkg::fold_t  mode_reg, mode_next;

    logic [8:0]  vert_count_reg;
    logic [6:0]  horiz_count_reg;
    logic [15:0] scale_reg;
    logic [23:0] peak_reg, peak_next;

    logic [38:0] prod_reg, prod_next;
    logic [13:0] gidx_reg, gidx_next;

    logic signed [15:0] theta_reg, theta_next;
    logic signed [PW-1:0] phi_reg, phi_next;
    logic signed [PW-1:0] lb_reg, lb_next;
    logic signed [PW-1:0] ub_reg, ub_next;
    logic signed [15:0] h0_reg, h0_next, h1_reg, h1_next;
    logic signed [15:0] v0a_reg, v0a_next, vla_reg, vla_next;

    logic          sel_h_reg, sel_h_next;
    logic [SW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic signed [15:0] alo_reg, alo_next, ahi_reg, ahi_next;

    logic [VAW-1:0] v0i_reg, v0i_next, v1i_reg, v1i_next;
    logic [HAW-1:0] ha_reg, ha_next, hb_reg, hb_next;
    logic [15:0]    tv_reg, tv_next, th_reg, th_next;

    logic [2:0]  gcnt_reg, gcnt_next;
    logic [23:0] c00_reg, c00_next, c01_reg, c01_next;
    logic [23:0] c10_reg, c10_next, c11_reg, c11_next;
    logic signed [40:0] c0_reg, c0_next, c1_reg, c1_next;
    logic [35:0]        pl_reg, pl_next;
    logic signed [38:0] ph_reg, ph_next;
    logic [40:0]        cq16_reg, cq16_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] intensity_reg, intensity_next;
    logic        outside_reg, outside_next;
    logic [15:0] res_reg, res_next;
    logic        res_out_reg, res_out_next;

    // memory ports
    logic           v_we, h_we, g_we;
    logic [VAW-1:0] v_addr;
    logic [HAW-1:0] h_addr;
    logic [GAW-1:0] g_addr;
    logic [15:0]    v_wdata, h_wdata, v_q, h_q;
    logic [23:0]    g_wdata, g_q;

    logic              div_start, div_done;
    pts_pkg::div_req_t div_req;
    logic [15:0]       div_quot;

    // working signals
    logic [8:0]  vc;
    logic [6:0]  hc;
    logic [15:0] sc;
    logic [SW-1:0] mid;
    logic signed [PW-1:0] loc_x;
    logic signed [15:0]   loc_a0, loc_an, q_sel;
    logic [SW-1:0]        loc_nm1;
    logic                 loc_done;
    logic [SW-1:0]        loc_i0, loc_i1;
    logic [15:0]          loc_t;
    logic signed [16:0]   span;
    logic [16:0]          span_abs;
    logic signed [PW-1:0] pm;
    logic signed [PW:0]   num_s, den_s;
    logic [HAW-1:0]       hsel;
    logic [VAW-1:0]       vsel;
    logic [HAW+9:0]       gsum;
    logic signed [24:0]   cdiff;
    logic signed [41:0]   cprod;
    logic signed [41:0]   dcc;
    logic signed [59:0]   cq32;
    logic [24:0]          dnorm;
    logic [23:0]          cd_sat;
    logic                 cd_in_range;

    always_comb
    begin
        if (vert_count_reg < 9'd2)
            vc = 9'd2;
        else if (32'(vert_count_reg) > pts_pkg::MAX_VERT)
            vc = 9'(pts_pkg::MAX_VERT);
        else
            vc = vert_count_reg;
        if (horiz_count_reg < 7'd1)
            hc = 7'd1;
        else if (32'(horiz_count_reg) > pts_pkg::MAX_HORIZ)
            hc = 7'(pts_pkg::MAX_HORIZ);
        else
            hc = horiz_count_reg;
        sc = (scale_reg == 16'd0) ? 16'd256 : scale_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vert_count_reg  <= 9'd2;
            horiz_count_reg <= 7'd1;
            scale_reg       <= 16'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pts_pkg::REG_VERT_COUNT:    vert_count_reg  <= cfg_data[8:0];
                pts_pkg::REG_HORIZ_COUNT:   horiz_count_reg <= cfg_data[6:0];
                pts_pkg::REG_CANDELA_SCALE: scale_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    assign mid = SW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);

    // operands of the bisection in progress
    always_comb
    begin
        if (sel_h_reg)
        begin
            loc_x   = phi_reg;
            loc_a0  = h0_reg;
            loc_an  = h1_reg;
            loc_nm1 = SW'(hc - 7'd1);
            q_sel   = h_q;
        end
        else
        begin
            loc_x   = PW'(theta_reg);
            loc_a0  = v0a_reg;
            loc_an  = vla_reg;
            loc_nm1 = SW'(vc - 9'd1);
            q_sel   = v_q;
        end
    end

    assign span     = 17'(h1_reg) - 17'(h0_reg);
    assign span_abs = (span < 0) ? 17'(-span) : 17'(span);
    assign num_s    = (PW+1)'(loc_x) - (PW+1)'(alo_reg);
    assign den_s    = (PW+1)'(ahi_reg) - (PW+1)'(alo_reg);

    assign hsel = gcnt_reg[1] ? hb_reg : ha_reg;
    assign vsel = gcnt_reg[0] ? v1i_reg : v0i_reg;
    assign gsum = (HAW+10)'((HAW+9)'(hsel) * (HAW+9)'(vc)) + (HAW+10)'(vsel);

    assign cd_sat = (prod_reg[38:32] != 7'd0) ? 24'hFFFFFF : prod_reg[31:8];
    assign cd_in_range = 32'(gidx_reg) < pts_pkg::GRID_DEPTH;

    assign dcc   = 42'(c1_reg) - 42'(c0_reg);
    assign dnorm = {((peak_reg == 24'd0) ? 24'd1 : peak_reg), 1'b0};

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        peak_next      = peak_reg;
        prod_next      = prod_reg;
        gidx_next      = gidx_reg;
        theta_next     = theta_reg;
        phi_next       = phi_reg;
        lb_next        = lb_reg;
        ub_next        = ub_reg;
        h0_next        = h0_reg;
        h1_next        = h1_reg;
        v0a_next       = v0a_reg;
        vla_next       = vla_reg;
        sel_h_next     = sel_h_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        alo_next       = alo_reg;
        ahi_next       = ahi_reg;
        v0i_next       = v0i_reg;
        v1i_next       = v1i_reg;
        ha_next        = ha_reg;
        hb_next        = hb_reg;
        tv_next        = tv_reg;
        th_next        = th_reg;
        gcnt_next      = gcnt_reg;
        c00_next       = c00_reg;
        c01_next       = c01_reg;
        c10_next       = c10_reg;
        c11_next       = c11_reg;
        c0_next        = c0_reg;
        c1_next        = c1_reg;
        pl_next        = pl_reg;
        ph_next        = ph_reg;
        cq16_next      = cq16_reg;
        res_next       = res_reg;
        res_out_next   = res_out_reg;
        out_valid_next = out_valid_reg;
        intensity_next = intensity_reg;
        outside_next   = outside_reg;
        in_ready       = 1'b0;
        v_we           = 1'b0;
        h_we           = 1'b0;
        g_we           = 1'b0;
        v_addr         = '0;
        h_addr         = '0;
        g_addr         = '0;
        v_wdata        = angle;
        h_wdata        = angle;
        g_wdata        = cd_sat;
        div_start      = 1'b0;
        div_req        = '0;
        loc_done       = 1'b0;
        loc_i0         = '0;
        loc_i1         = '0;
        loc_t          = '0;
        pm             = phi_reg;
        cdiff          = '0;
        cprod          = '0;
        cq32           = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            pts_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (kind)
                        pts_pkg::KIND_VERT:
                        begin
                            v_we   = 32'(index) < pts_pkg::MAX_VERT;
                            v_addr = VAW'(index);
                        end
                        pts_pkg::KIND_HORIZ:
                        begin
                            h_we   = 32'(index) < pts_pkg::MAX_HORIZ;
                            h_addr = HAW'(index);
                        end
                        pts_pkg::KIND_CANDELA:
                        begin
                            prod_next  = (raw_candela > 0) ? raw_candela[22:0] * sc : '0;
                            gidx_next  = index;
                            state_next = pts_pkg::S_CD_WR;
                        end
                        pts_pkg::KIND_SAMPLE:
                        begin
                            theta_next = theta;
                            phi_next   = PW'(phi);
                            state_next = pts_pkg::S_RD0;
                        end
                        default: ;
                    endcase
                end
            end
            pts_pkg::S_CD_WR:
            begin
                g_we   = cd_in_range;
                g_addr = GAW'(gidx_reg);
                if (cd_in_range && (cd_sat > peak_reg))
                    peak_next = cd_sat;
                state_next = pts_pkg::S_IDLE;
            end
            pts_pkg::S_RD0:
            begin
                state_next = pts_pkg::S_RD1;
            end
            pts_pkg::S_RD1:
            begin
                h0_next    = h_q;
                v0a_next   = v_q;
                h_addr     = HAW'(hc - 7'd1);
                v_addr     = VAW'(vc - 9'd1);
                state_next = pts_pkg::S_RD2;
            end
            pts_pkg::S_RD2:
            begin
                h1_next    = h_q;
                vla_next   = v_q;
                state_next = pts_pkg::S_FOLD;
            end
            pts_pkg::S_FOLD:
            begin
                sel_h_next = 1'b0;
                if (theta_reg < v0a_reg || theta_reg > vla_reg)
                begin
                    res_next     = '0;
                    res_out_next = 1'b1;
                    state_next   = pts_pkg::S_DONE;
                end
                else
                begin
                    res_out_next = 1'b0;
                    if (hc == 7'd1)
                    begin
                        phi_next   = PW'(h0_reg);
                        mode_next  = pts_pkg::FOLD_NONE;
                        state_next = pts_pkg::S_LOC;
                    end
                    else
                    begin
                        if (32'(span_abs) <= pts_pkg::DEG90_LIM)
                            mode_next = pts_pkg::FOLD_QUAD;
                        else if (32'(span_abs) <= pts_pkg::DEG180_LIM)
                            mode_next = pts_pkg::FOLD_HALF;
                        else
                            mode_next = pts_pkg::FOLD_WRAP;
                        if (32'(span_abs) <= pts_pkg::DEG180_LIM)
                        begin
                            lb_next = '0;
                            ub_next = PW'(pts_pkg::DEG360 - 1);
                        end
                        else
                        begin
                            lb_next = PW'(h0_reg);
                            ub_next = PW'(h1_reg) + PW'(pts_pkg::WRAP_SLACK);
                        end
                        state_next = pts_pkg::S_ADJ_LO;
                    end
                end
            end
            pts_pkg::S_ADJ_LO:
            begin
                if (phi_reg < lb_reg)
                    phi_next = phi_reg + PW'(pts_pkg::DEG360);
                else
                    state_next = pts_pkg::S_ADJ_HI;
            end
            pts_pkg::S_ADJ_HI:
            begin
                if (phi_reg > ub_reg)
                    phi_next = phi_reg - PW'(pts_pkg::DEG360);
                else
                    state_next = pts_pkg::S_MIRROR;
            end
            pts_pkg::S_MIRROR:
            begin
                // mirror the wrapped angle into the stored quadrant or half
                if (mode_reg == pts_pkg::FOLD_QUAD || mode_reg == pts_pkg::FOLD_HALF)
                begin
                    if (pm > PW'(pts_pkg::DEG180))
                        pm = PW'(pts_pkg::DEG360) - pm;
                    if (mode_reg == pts_pkg::FOLD_QUAD && pm > PW'(pts_pkg::DEG90))
                        pm = PW'(pts_pkg::DEG180) - pm;
                end
                phi_next   = pm;
                state_next = pts_pkg::S_LOC;
            end
            pts_pkg::S_LOC:
            begin
                if ((sel_h_reg && hc == 7'd1) || loc_x <= PW'(loc_a0))
                begin
                    loc_done = 1'b1;
                end
                else if (loc_x >= PW'(loc_an))
                begin
                    loc_done = 1'b1;
                    loc_i0   = loc_nm1;
                    loc_i1   = loc_nm1;
                end
                else
                begin
                    lo_next  = '0;
                    hi_next  = loc_nm1;
                    alo_next = loc_a0;
                    ahi_next = loc_an;
                    if (loc_nm1 > SW'(1))
                        state_next = pts_pkg::S_SRCH_RD;
                    else
                        state_next = pts_pkg::S_TDIV;
                end
            end
            pts_pkg::S_SRCH_RD:
            begin
                v_addr     = VAW'(mid);
                h_addr     = HAW'(mid);
                state_next = pts_pkg::S_SRCH_CMP;
            end
            pts_pkg::S_SRCH_CMP:
            begin
                if (PW'(q_sel) <= loc_x)
                begin
                    lo_next  = mid;
                    alo_next = q_sel;
                end
                else
                begin
                    hi_next  = mid;
                    ahi_next = q_sel;
                end
                if ((hi_next - lo_next) > SW'(1))
                    state_next = pts_pkg::S_SRCH_RD;
                else
                    state_next = pts_pkg::S_TDIV;
            end
            pts_pkg::S_TDIV:
            begin
                if (den_s > 0 && num_s >= 0)
                begin
                    div_start     = 1'b1;
                    div_req.rem   = pts_pkg::DIV_W'(num_s);
                    div_req.den   = pts_pkg::DIV_W'(den_s);
                    div_req.steps = 5'd16;
                    state_next    = pts_pkg::S_TWAIT;
                end
                else
                begin
                    loc_done = 1'b1;
                    loc_i0   = lo_reg;
                    loc_i1   = hi_reg;
                end
            end
            pts_pkg::S_TWAIT:
            begin
                if (div_done)
                begin
                    loc_done = 1'b1;
                    loc_i0   = lo_reg;
                    loc_i1   = hi_reg;
                    loc_t    = div_quot;
                end
            end
            pts_pkg::S_GRID:
            begin
                g_addr    = GAW'(gsum);
                gcnt_next = gcnt_reg + 3'd1;
                case (gcnt_reg)
                    3'd1:    c00_next = g_q;
                    3'd2:    c01_next = g_q;
                    3'd3:    c10_next = g_q;
                    3'd4:    c11_next = g_q;
                    default: ;
                endcase
                if (gcnt_reg == 3'd4)
                    state_next = pts_pkg::S_IC0;
            end
            pts_pkg::S_IC0:
            begin
                cdiff      = 25'(c01_reg) - 25'(c00_reg);
                cprod      = 42'(cdiff * $signed({1'b0, tv_reg}));
                c0_next    = 41'($signed({2'b00, c00_reg, 16'h0000}) + cprod);
                state_next = pts_pkg::S_IC1;
            end
            pts_pkg::S_IC1:
            begin
                cdiff      = 25'(c11_reg) - 25'(c10_reg);
                cprod      = 42'(cdiff * $signed({1'b0, tv_reg}));
                c1_next    = 41'($signed({2'b00, c10_reg, 16'h0000}) + cprod);
                state_next = pts_pkg::S_IPL;
            end
            pts_pkg::S_IPL:
            begin
                // low partial product of the second lerp; S_IPH forms the high one
                pl_next    = dcc[19:0] * th_reg;
                state_next = pts_pkg::S_IPH;
            end
            pts_pkg::S_IPH:
            begin
                ph_next    = 39'($signed(dcc[41:20]) * $signed({1'b0, th_reg}));
                state_next = pts_pkg::S_SUM;
            end
            pts_pkg::S_SUM:
            begin
                cq32 = 60'($signed({c0_reg, 16'h0000}))
                     + 60'($signed({ph_reg, 20'h00000}))
                     + 60'($signed({1'b0, pl_reg}));
                cq16_next  = (cq32 < 0) ? '0 : cq32[56:16];
                state_next = pts_pkg::S_NORM;
            end
            pts_pkg::S_NORM:
            begin
                if (cq16_reg >= {1'b0, dnorm, 15'h0000})
                begin
                    res_next   = 16'h8000;
                    state_next = pts_pkg::S_DONE;
                end
                else
                begin
                    div_start       = 1'b1;
                    div_req.rem     = cq16_reg[40:15];
                    div_req.lo_bits = {cq16_reg[14:0], 1'b0};
                    div_req.den     = pts_pkg::DIV_W'(dnorm);
                    div_req.steps   = 5'd15;
                    state_next      = pts_pkg::S_NWAIT;
                end
            end
            pts_pkg::S_NWAIT:
            begin
                if (div_done)
                begin
                    res_next   = div_quot;
                    state_next = pts_pkg::S_DONE;
                end
            end
            pts_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    intensity_next = res_reg;
                    outside_next   = res_out_reg;
                    state_next     = pts_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pts_pkg::S_IDLE;
            end
        endcase

        // end of one bisection: keep the cell, move on
        if (loc_done)
        begin
            if (sel_h_reg)
            begin
                ha_next    = HAW'(loc_i0);
                hb_next    = HAW'(loc_i1);
                th_next    = loc_t;
                gcnt_next  = '0;
                state_next = pts_pkg::S_GRID;
            end
            else
            begin
                v0i_next   = VAW'(loc_i0);
                v1i_next   = VAW'(loc_i1);
                tv_next    = loc_t;
                sel_h_next = 1'b1;
                state_next = pts_pkg::S_LOC;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pts_pkg::S_IDLE;
            mode_reg      <= pts_pkg::FOLD_NONE;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
            sel_h_reg     <= 1'b0;
            gcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
            sel_h_reg     <= sel_h_next;
            gcnt_reg      <= gcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        gidx_reg      <= gidx_next;
        theta_reg     <= theta_next;
        phi_reg       <= phi_next;
        lb_reg        <= lb_next;
        ub_reg        <= ub_next;
        h0_reg        <= h0_next;
        h1_reg        <= h1_next;
        v0a_reg       <= v0a_next;
        vla_reg       <= vla_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        alo_reg       <= alo_next;
        ahi_reg       <= ahi_next;
        v0i_reg       <= v0i_next;
        v1i_reg       <= v1i_next;
        ha_reg        <= ha_next;
        hb_reg        <= hb_next;
        tv_reg        <= tv_next;
        th_reg        <= th_next;
        c00_reg       <= c00_next;
        c01_reg       <= c01_next;
        c10_reg       <= c10_next;
        c11_reg       <= c11_next;
        c0_reg        <= c0_next;
        c1_reg        <= c1_next;
        pl_reg        <= pl_next;
        ph_reg        <= ph_next;
        cq16_reg      <= cq16_next;
        res_reg       <= res_next;
        res_out_reg   <= res_out_next;
        intensity_reg <= intensity_next;
        outside_reg   <= outside_next;
    end

    pts_ram #(
        .WIDTH(16),
        .DEPTH(pts_pkg::MAX_VERT)
    ) u_vert_ram (
        .clk  (clk),
        .we   (v_we),
        .addr (v_addr),
        .wdata(v_wdata),
        .rdata(v_q)
    );

    pts_ram #(
        .WIDTH(16),
        .DEPTH(pts_pkg::MAX_HORIZ)
    ) u_horiz_ram (
        .clk  (clk),
        .we   (h_we),
        .addr (h_addr),
        .wdata(h_wdata),
        .rdata(h_q)
    );

    pts_ram #(
        .WIDTH(24),
        .DEPTH(pts_pkg::GRID_DEPTH)
    ) u_grid_ram (
        .clk  (clk),
        .we   (g_we),
        .addr (g_addr),
        .wdata(g_wdata),
        .rdata(g_q)
    );

    pts_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .req  (div_req),
        .done (div_done),
        .quot (div_quot)
    );

    assign out_valid     = out_valid_reg;
    assign intensity     = intensity_reg;
    assign outside_range = outside_reg;

    a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> peak_reg >= $past(peak_reg))
        else $error("peak candela decreased");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && outside_reg |-> intensity_reg == 16'd0)
        else $error("nonzero intensity for out-of-range theta");

    a_intensity_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> intensity_reg <= 16'h8000)
        else $error("intensity above full scale");

    a_bisect_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pts_pkg::S_SRCH_CMP |-> hi_reg > lo_reg)
        else $error("bisection bounds crossed");

    a_sample_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == pts_pkg::KIND_SAMPLE |=> state_reg == pts_pkg::S_RD0)
        else $error("sample word did not start table read");

endmodule

[rtl/pts_ram.sv]
// generic single-port ram with registered read
module pts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pts_div.sv]
// restoring divider, one quotient bit per cycle
module pts_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pts_pkg::div_req_t req,
    output logic              done,
    output logic [15:0]       quot
);

    logic [pts_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [pts_pkg::DIV_W-1:0] den_reg, den_next;
    logic [15:0]               lo_reg, lo_next;
    logic [15:0]               quot_reg, quot_next;
    logic [4:0]                cnt_reg, cnt_next;
    logic                      done_reg, done_next;
    logic [pts_pkg::DIV_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        lo_next   = lo_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = {rem_reg, lo_reg[15]};
        if (start)
        begin
            rem_next  = req.rem;
            den_next  = req.den;
            lo_next   = req.lo_bits;
            quot_next = '0;
            cnt_next  = req.steps;
        end
        else if (cnt_reg != 5'd0)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = pts_pkg::DIV_W'(trial - {1'b0, den_reg});
                quot_next = {quot_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[pts_pkg::DIV_W-1:0];
                quot_next = {quot_reg[14:0], 1'b0};
            end
            lo_next   = {lo_reg[14:0], 1'b0};
            cnt_next  = cnt_reg - 5'd1;
            done_next = (cnt_reg == 5'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            den_reg  <= '0;
            lo_reg   <= '0;
            quot_reg <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            lo_reg   <= lo_next;
            quot_reg <= quot_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
